// ===== rtl/core/efla_pkg.sv =====
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types and constants for the free list allocator.
// ----------------------------------------------------------------------------
package efla_pkg;
   localparam int HEAP_BYTES_DEF = 1048576;
   localparam int SEARCH_LIMIT_RESET = 250;
   localparam logic [31:0] MIN_BLOCK = 32'd32;
   localparam logic [31:0] TAG_BYTES = 32'd4;
   localparam logic [31:0] PAIR_BYTES = 32'd8;
   localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NULL = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE = 1'b1;

   typedef struct packed {
      logic        we;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_cmd_type;
endpackage

// ===== rtl/core/explicit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// explicit_free_list_allocator_unit
// Boundary tag heap allocator with a first-fit LIFO free list.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | tdata: func[0], request_size[21:1], block_addr[41:22]
// rsp     | out | tdata: result_addr[19:0], status[21:20]
// csr     | in  | search_limit[9:0]
// An allocate walks the free list, visiting at most search_limit nodes, before
// it grows the heap; a release coalesces with free neighbours. All heap accesses
// share one RAM port with registered read. The prologue words are tracked by two flags, so
// no clearing pass follows reset. req_tready is low while a transaction is in
// work and while a result waits on rsp.
module explicit_free_list_allocator_unit
   import efla_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // func, request_size, block_addr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result_addr, status
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata    // search_limit
);
   localparam logic [5:0]
      S_IDLE = 6'd0, S_RESP = 6'd1,
      A_START = 6'd2, A_RDH = 6'd3, A_CHK = 6'd4, A_RDN = 6'd5, A_NXT = 6'd6,
      A_SP1 = 6'd7, A_SP2 = 6'd8, A_SP3 = 6'd9, A_SP4 = 6'd10,
      A_WH1 = 6'd11, A_WH2 = 6'd12,
      A_G1 = 6'd13, A_G2 = 6'd14, A_G3 = 6'd15,
      U_RDN = 6'd16, U_RDP = 6'd17, U_W1 = 6'd18, U_W2 = 6'd19,
      R_RH = 6'd20, R_W1 = 6'd21, R_W2 = 6'd22, R_RN = 6'd23, R_RP = 6'd24,
      R_CASE = 6'd25, R_RNB = 6'd26, R_RPB = 6'd27,
      T_W1 = 6'd28, T_W2 = 6'd29,
      P_W1 = 6'd30, P_W2 = 6'd31, P_W3 = 6'd32,
      U_WAIT = 6'd33, U_WAIT2 = 6'd34, R_WAIT = 6'd35;

   localparam logic [1:0] UR_ALLOC = 2'd0, UR_NB = 2'd1;
   localparam logic [1:0] TR_ALLOC = 2'd0, TR_PUSH = 2'd1, TR_DONE = 2'd2;

   logic [5:0]  state_ff, state_in;
   logic [9:0]  limit_ff, limit_in;
   logic [31:0] top_ff, top_in, head_ff, head_in;
   logic [31:0] need_ff, need_in, node_ff, node_in, fsz_ff, fsz_in;
   logic [31:0] p_ff, p_in, size_ff, size_in, tmp_ff, tmp_in;
   logic [31:0] nx_ff, nx_in, pv_ff, pv_in, ta_ff, ta_in, tv_ff, tv_in;
   logic [31:0] nb_ff, nb_in, pb_ff, pb_in, na_ff, na_in;
   logic [9:0]  cnt_ff, cnt_in;
   logic [19:0] ra_ff, ra_in;
   logic [1:0]  st_ff, st_in;
   logic [1:0]  ur_ff, ur_in, tr_ff, tr_in;
   logic [1:0]  cs_ff, cs_in;
   mem_cmd_type cmd;
   logic [31:0] rd;
   logic [31:0] sum;
   logic [31:0] au_a, au_b;
   logic        req_acc;

   logic        in_func;
   logic [20:0] in_size;
   logic [19:0] in_addr;
   assign in_func = req_tdata[0];
   assign in_size = req_tdata[21:1];
   assign in_addr = req_tdata[41:22];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata = {2'b00, st_ff, ra_ff};
   assign sum = au_a + au_b;

   efla_heap_port #(.HEAP_BYTES(HEAP_BYTES)) u_heap (
      .clock(clock), .reset(reset), .cmd(cmd), .rdata(rd)
   );

   always_comb begin
      state_in = state_ff; limit_in = csr_we ? csr_wdata : limit_ff;
      top_in = top_ff; head_in = head_ff; need_in = need_ff; node_in = node_ff;
      fsz_in = fsz_ff; p_in = p_ff; size_in = size_ff; tmp_in = tmp_ff;
      nx_in = nx_ff; pv_in = pv_ff; ta_in = ta_ff; tv_in = tv_ff;
      nb_in = nb_ff; pb_in = pb_ff; na_in = na_ff; cnt_in = cnt_ff;
      ra_in = ra_ff; st_in = st_ff; ur_in = ur_ff; tr_in = tr_ff; cs_in = cs_ff;
      cmd = '{we: 1'b0, addr: 32'd0, wdata: 32'd0};
      au_a = 32'd0; au_b = 32'd0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               ra_in = 20'd0; st_in = ST_OK;
               if (in_func == FUNC_ALLOC) begin
                  if (in_size == 21'd0) begin
                     st_in = ST_ZERO; state_in = S_RESP;
                  end else begin
                     au_a = {11'd0, in_size}; au_b = 32'd7;
                     need_in = ({11'd0, in_size} > MIN_BLOCK) ? (sum & SIZE_MASK)
                                                             : MIN_BLOCK;
                     node_in = head_ff; cnt_in = 10'd0; state_in = A_START;
                  end
               end else if (in_addr == 20'd0) begin
                  st_in = ST_NULL; state_in = S_RESP;
               end else begin
                  p_in = {12'd0, in_addr};
                  cmd.addr = {12'd0, in_addr} - TAG_BYTES;
                  state_in = R_RH;
               end
            end
         end
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         A_START: begin
            if (node_ff != 32'd0 && cnt_ff < limit_ff) begin
               cmd.addr = node_ff - TAG_BYTES; state_in = A_RDH;
            end else begin
               au_a = top_ff; au_b = need_ff + PAIR_BYTES;
               if ({1'b0, sum} > 33'(HEAP_BYTES) || sum < top_ff) begin
                  st_in = ST_FULL; state_in = S_RESP;
               end else begin
                  ra_in = top_ff[19:0]; p_in = top_ff; top_in = sum;
                  state_in = A_G1;
               end
            end
         end
         A_RDH: begin
            cmd.addr = node_ff - TAG_BYTES; state_in = A_CHK;
         end
         A_CHK: begin
            fsz_in = rd & SIZE_MASK;
            if ((rd & SIZE_MASK) >= need_ff) begin
               au_a = need_ff; au_b = MIN_BLOCK;
               ra_in = node_ff[19:0];
               if ((rd & SIZE_MASK) >= sum) state_in = A_SP1;
               else begin
                  p_in = node_ff; ur_in = UR_ALLOC;
                  cmd.addr = node_ff + PAIR_BYTES; state_in = U_WAIT;
               end
            end else begin
               cmd.addr = node_ff + PAIR_BYTES; state_in = A_RDN;
            end
         end
         A_RDN: begin
            cmd.addr = node_ff + PAIR_BYTES; state_in = A_NXT;
         end
         A_NXT: begin
            node_in = rd << 2; cnt_in = cnt_ff + 10'd1; state_in = A_START;
         end
         A_SP1: begin
            au_a = fsz_ff; au_b = ~need_ff + 32'd1;
            tmp_in = sum - PAIR_BYTES; state_in = A_SP2;
         end
         A_SP2: begin
            cmd = '{we: 1'b1, addr: node_ff - TAG_BYTES, wdata: tmp_ff};
            au_a = node_ff; au_b = tmp_ff;
            p_in = sum + PAIR_BYTES; state_in = A_SP3;
         end
         A_SP3: begin
            cmd = '{we: 1'b1, addr: node_ff + (tmp_ff & SIZE_MASK), wdata: tmp_ff};
            ra_in = p_ff[19:0]; state_in = A_SP4;
         end
         A_SP4: begin
            cmd = '{we: 1'b1, addr: p_ff - TAG_BYTES, wdata: need_ff | 32'd1};
            au_a = p_ff; au_b = need_ff & SIZE_MASK;
            ta_in = sum; tv_in = need_ff | 32'd1; state_in = A_WH2;
         end
         A_WH1: begin
            cmd = '{we: 1'b1, addr: p_ff - TAG_BYTES, wdata: tv_ff};
            au_a = p_ff; au_b = tv_ff & SIZE_MASK;
            ta_in = sum; state_in = A_WH2;
         end
         A_WH2: begin
            cmd = '{we: 1'b1, addr: ta_ff, wdata: tv_ff};
            state_in = S_RESP;
         end
         A_G1: begin
            cmd = '{we: 1'b1, addr: p_ff - TAG_BYTES, wdata: need_ff | 32'd1};
            state_in = A_G2;
         end
         A_G2: begin
            au_a = p_ff; au_b = need_ff;
            cmd = '{we: 1'b1, addr: sum, wdata: need_ff | 32'd1};
            state_in = A_G3;
         end
         A_G3: begin
            au_a = p_ff; au_b = need_ff + TAG_BYTES;
            cmd = '{we: 1'b1, addr: sum, wdata: 32'd1};
            state_in = S_RESP;
         end
         U_WAIT: begin
            cmd.addr = p_ff + PAIR_BYTES; state_in = U_RDN;
         end
         U_RDN: begin
            cmd.addr = p_ff;
            nx_in = rd << 2; state_in = U_RDP;
         end
         U_RDP: begin
            pv_in = rd << 2;
            if ((rd << 2) == 32'd0) begin
               head_in = nx_ff; state_in = U_W2;
            end else begin
               state_in = U_W1;
            end
         end
         U_W1: begin
            cmd = '{we: 1'b1, addr: pv_ff + PAIR_BYTES, wdata: nx_ff >> 2};
            state_in = U_W2;
         end
         U_W2: begin
            if (nx_ff != 32'd0) cmd = '{we: 1'b1, addr: nx_ff, wdata: pv_ff >> 2};
            if (ur_ff == UR_ALLOC) begin
               tv_in = fsz_ff | 32'd1; state_in = A_WH1;
            end else begin
               state_in = U_WAIT2;
            end
         end
         U_WAIT2: begin
            if (cs_ff == 2'd1) begin
               tv_in = size_ff; tr_in = TR_PUSH; state_in = T_W1;
            end else begin
               state_in = S_RESP;
            end
         end
         R_RH: begin
            cmd.addr = p_ff - TAG_BYTES; state_in = R_W1;
         end
         R_W1: begin
            size_in = rd & SIZE_MASK;
            cmd = '{we: 1'b1, addr: p_ff - TAG_BYTES, wdata: rd & SIZE_MASK};
            state_in = R_W2;
         end
         R_W2: begin
            au_a = p_ff; au_b = size_ff;
            cmd = '{we: 1'b1, addr: sum, wdata: size_ff};
            state_in = (head_ff == 32'd0) ? P_W1 : R_WAIT;
         end
         R_WAIT: begin
            au_a = p_ff; au_b = size_ff + TAG_BYTES;
            cmd.addr = sum; nb_in = sum + TAG_BYTES; state_in = R_RN;
         end
         R_RN: begin
            na_in = rd;
            cmd.addr = p_ff - PAIR_BYTES; state_in = R_RP;
         end
         R_RP: begin
            cmd.addr = p_ff - PAIR_BYTES; state_in = R_CASE;
         end
         R_CASE: begin
            pb_in = p_ff - (rd & SIZE_MASK) - PAIR_BYTES;
            tmp_in = rd;
            if (rd[0] && na_ff[0]) state_in = P_W1;
            else begin
               cmd.addr = nb_ff - TAG_BYTES;
               cs_in = {!na_ff[0], !rd[0]} == 2'b10 ? 2'd1 :
                       ({!na_ff[0], !rd[0]} == 2'b01 ? 2'd2 : 2'd3);
               state_in = R_RNB;
            end
         end
         R_RNB: begin
            cmd.addr = pb_ff - TAG_BYTES;
            state_in = R_RPB;
            fsz_in = rd & SIZE_MASK;
         end
         R_RPB: begin
            // fsz_ff: next block size, rd: previous block size
            case (cs_ff)
               2'd1: begin
                  size_in = size_ff + fsz_ff + PAIR_BYTES;
                  p_in = nb_ff; ur_in = UR_NB;
                  pb_in = p_ff; state_in = U_WAIT;
               end
               2'd2: begin
                  size_in = size_ff + (rd & SIZE_MASK) + PAIR_BYTES;
                  tv_in = size_ff + (rd & SIZE_MASK) + PAIR_BYTES;
                  tr_in = TR_DONE; state_in = T_W1;
               end
               default: begin
                  size_in = size_ff + (rd & SIZE_MASK) + fsz_ff + 32'd16;
                  tv_in = size_ff + (rd & SIZE_MASK) + fsz_ff + 32'd16;
                  tr_in = TR_ALLOC; state_in = T_W1;
               end
            endcase
         end
         T_W1: begin
            cmd = '{we: 1'b1, addr: pb_ff - TAG_BYTES, wdata: tv_ff};
            state_in = T_W2;
         end
         T_W2: begin
            au_a = pb_ff; au_b = tv_ff & SIZE_MASK;
            cmd = '{we: 1'b1, addr: sum, wdata: tv_ff};
            if (tr_ff == TR_PUSH) begin
               p_in = pb_ff; state_in = P_W1;
            end else if (tr_ff == TR_ALLOC) begin
               p_in = nb_ff; ur_in = UR_NB; cs_in = 2'd3; state_in = U_WAIT;
            end else begin
               state_in = S_RESP;
            end
         end
         P_W1: begin
            cmd = '{we: 1'b1, addr: p_ff + PAIR_BYTES, wdata: head_ff >> 2};
            state_in = P_W2;
         end
         P_W2: begin
            cmd = '{we: 1'b1, addr: p_ff, wdata: 32'd0};
            state_in = P_W3;
         end
         P_W3: begin
            if (head_ff != 32'd0) cmd = '{we: 1'b1, addr: head_ff, wdata: p_ff >> 2};
            head_in = p_ff; state_in = S_RESP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; limit_ff <= 10'(SEARCH_LIMIT_RESET);
         top_ff <= 32'd8; head_ff <= 32'd0; cs_ff <= 2'd0;
      end else begin
         state_ff <= state_in; limit_ff <= limit_in;
         top_ff <= top_in; head_ff <= head_in; cs_ff <= cs_in;
      end
      need_ff <= need_in; node_ff <= node_in; fsz_ff <= fsz_in; p_ff <= p_in;
      size_ff <= size_in; tmp_ff <= tmp_in; nx_ff <= nx_in; pv_ff <= pv_in;
      ta_ff <= ta_in; tv_ff <= tv_in; nb_ff <= nb_in; pb_ff <= pb_in;
      na_ff <= na_in; cnt_ff <= cnt_in; ra_ff <= ra_in; st_ff <= st_in;
      ur_ff <= ur_in; tr_ff <= tr_in;
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_top_grow: assert property (@(posedge clock) disable iff (reset)
      top_ff >= $past(top_ff)) else $error("heap top shrank");
`endif
endmodule

// ===== rtl/core/efla_ram.sv =====
// ----------------------------------------------------------------------------
// efla_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module efla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ===== rtl/core/efla_heap_port.sv =====
// ----------------------------------------------------------------------------
// efla_heap_port
// Heap word store: byte address to word index, prologue words read as 1 until first written.
// ----------------------------------------------------------------------------
module efla_heap_port
   import efla_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type cmd,
   output logic [31:0] rdata
);
   localparam int WORDS = HEAP_BYTES / 4;
   localparam int AW = $clog2(WORDS);
   logic [AW-1:0] idx;
   logic [31:0]   raw;
   logic          pro_ff, pro_in;
   logic          init0_ff, init1_ff;
   logic          init0_in, init1_in;

   assign idx = cmd.addr[AW+1:2];
   assign pro_in = (idx == '0 && !init0_ff) || (idx == AW'(1) && !init1_ff);
   assign init0_in = init0_ff || (cmd.we && idx == '0);
   assign init1_in = init1_ff || (cmd.we && idx == AW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pro_ff <= 1'b0;
         init0_ff <= 1'b0;
         init1_ff <= 1'b0;
      end else begin
         pro_ff <= pro_in;
         init0_ff <= init0_in;
         init1_ff <= init1_in;
      end
   end

   efla_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
      .clock(clock), .we(cmd.we), .addr(idx), .wdata(cmd.wdata), .rdata(raw)
   );

   assign rdata = pro_ff ? 32'd1 : raw;
endmodule
